// ===== hw/rtl/scs_pkg.sv =====
package scs_pkg;

   localparam int MAX_LEN   = 32;
   localparam int LEN_W     = $clog2(MAX_LEN + 1);
   localparam int IDX_W     = $clog2(MAX_LEN);
   localparam int TBL_W     = MAX_LEN + 1;
   localparam int TBL_DEPTH = TBL_W * TBL_W;
   localparam int TBL_AW    = $clog2(TBL_DEPTH);
   localparam int VAL_W     = LEN_W;
   localparam int MRG_DEPTH = 2 * MAX_LEN;
   localparam int MRG_AW    = $clog2(MRG_DEPTH);
   localparam int CNT_W     = $clog2(MRG_DEPTH + 1);
   localparam int PROD_W    = TBL_AW + LEN_W;

   typedef enum logic [1:0] {
      KIND_FIRST   = 2'd0,
      KIND_SECOND  = 2'd1,
      KIND_COMPUTE = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_TB_RD,
      ST_TB_WR,
      ST_EM_RD,
      ST_EM_LD,
      ST_EM_OUT
   } state_type;

   // Row-major address of cell (row, col) in the LCS length table.
   function automatic logic [TBL_AW-1:0] tbl_addr(input logic [LEN_W-1:0] row,
                                                 input logic [LEN_W-1:0] col);
      logic [PROD_W-1:0] full;
      full = PROD_W'(row) * PROD_W'(TBL_W) + PROD_W'(col);
      return full[TBL_AW-1:0];
   endfunction

endpackage

// ===== hw/rtl/shortest_common_supersequence_unit.sv =====
// Shortest common supersequence of two byte strings of up to 32 symbols each.
// A beat of kind 0 or 1 appends its symbol to the first or second string; a
// symbol beyond 32 is dropped and sets the overflow flag of the pair. A compute
// beat fills the LCS length table in a table memory with two read ports and a
// write port, with a read state and a write state per cell, traces it back
// with a read state and a write state per output symbol, and then returns the
// supersequence front to back, one beat per symbol with last on the final one,
// each beat read from the merge memory, loaded and offered in turn. Two empty
// strings give one beat with empty_res set. The input stalls from the compute
// beat until the last result beat is taken, and both strings are then empty.
module shortest_common_supersequence_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_symbol,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_symbol,
   output logic       rsp_last,
   output logic       rsp_empty_res,
   output logic       rsp_overflow
);

   localparam int LEN_W  = scs_pkg::LEN_W;
   localparam int IDX_W  = scs_pkg::IDX_W;
   localparam int TBL_AW = scs_pkg::TBL_AW;
   localparam int VAL_W  = scs_pkg::VAL_W;
   localparam int MRG_AW = scs_pkg::MRG_AW;
   localparam int CNT_W  = scs_pkg::CNT_W;

   scs_pkg::state_type state_ff, state_in;

   logic [LEN_W-1:0] len1_ff, len1_in, len2_ff, len2_in;
   logic             drop_ff, drop_in, ovf_ff, ovf_in;
   logic [LEN_W-1:0] m_ff, m_in, n_ff, n_in, i_ff, i_in, j_ff, j_in;
   logic [VAL_W-1:0] left_ff, left_in, diag_ff, diag_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [7:0]       rsp_sym_ff, rsp_sym_in;
   logic             rsp_last_ff, rsp_last_in, rsp_empty_ff, rsp_empty_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic [7:0]       t1_mem [scs_pkg::MAX_LEN];
   logic [7:0]       t2_mem [scs_pkg::MAX_LEN];
   logic [VAL_W-1:0] tbl_mem [scs_pkg::TBL_DEPTH];
   logic [7:0]       mrg_mem [scs_pkg::MRG_DEPTH];

   logic             t1_we, t2_we, tbl_we, mrg_we;
   logic [IDX_W-1:0] t1_waddr, t2_waddr, t1_raddr, t2_raddr;
   logic [TBL_AW-1:0] tbl_waddr, tbl_raddr_a, tbl_raddr_b;
   logic [VAL_W-1:0] tbl_wdata;
   logic [MRG_AW-1:0] mrg_waddr, mrg_raddr;
   logic [7:0]       mrg_wdata;

   logic [7:0]       t1_rd_ff, t2_rd_ff, mrg_rd_ff;
   logic [VAL_W-1:0] tbl_rd_a_ff, tbl_rd_b_ff;

   logic             req_accept, rsp_accept;
   logic [LEN_W-1:0] i_m1, j_m1;
   logic [CNT_W-1:0] k_m1;
   logic             sym_eq, both_left, take2, dec_i, dec_j, pair_empty, any_empty;
   logic [VAL_W-1:0] up_val, left_val, tb_left, tb_up, cell_val;
   logic [LEN_W-1:0] i_next_tb, j_next_tb;

   assign req_stall  = (state_ff != scs_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (state_ff == scs_pkg::ST_EM_OUT);
   assign rsp_accept = rsp_valid && !rsp_stall;

   assign rsp_out_symbol = rsp_sym_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_empty_res  = rsp_empty_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   assign i_m1 = i_ff - LEN_W'(1);
   assign j_m1 = j_ff - LEN_W'(1);
   assign k_m1 = k_ff - CNT_W'(1);

   assign pair_empty = (len1_ff == '0) && (len2_ff == '0);
   assign any_empty  = (len1_ff == '0) || (len2_ff == '0);

   // Cell update during the table fill.
   assign sym_eq   = (t1_rd_ff == t2_rd_ff);
   assign up_val   = (i_ff == LEN_W'(1)) ? '0 : tbl_rd_a_ff;
   assign left_val = left_ff;
   assign cell_val = sym_eq ? VAL_W'(diag_ff + VAL_W'(1))
                            : ((up_val > left_val) ? up_val : left_val);

   // Step decision during the trace back.
   assign tb_left   = (j_ff == LEN_W'(1)) ? '0 : tbl_rd_a_ff;
   assign tb_up     = (i_ff == LEN_W'(1)) ? '0 : tbl_rd_b_ff;
   assign both_left = (i_ff != '0) && (j_ff != '0);
   assign take2     = both_left ? (!sym_eq && (tb_left > tb_up)) : (i_ff == '0);
   assign dec_i     = both_left ? (sym_eq || !take2) : (i_ff != '0);
   assign dec_j     = both_left ? (sym_eq || take2) : (i_ff == '0);
   assign i_next_tb = dec_i ? i_m1 : i_ff;
   assign j_next_tb = dec_j ? j_m1 : j_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scs_pkg::ST_IDLE: begin
            if (req_accept && (req_kind == scs_pkg::KIND_COMPUTE)) begin
               if (pair_empty) begin
                  state_in = scs_pkg::ST_EM_OUT;
               end else if (any_empty) begin
                  state_in = scs_pkg::ST_TB_RD;
               end else begin
                  state_in = scs_pkg::ST_FILL_RD;
               end
            end
         end
         scs_pkg::ST_FILL_RD: state_in = scs_pkg::ST_FILL_WR;
         scs_pkg::ST_FILL_WR: begin
            if ((j_ff == n_ff) && (i_ff == m_ff)) begin
               state_in = scs_pkg::ST_TB_RD;
            end else begin
               state_in = scs_pkg::ST_FILL_RD;
            end
         end
         scs_pkg::ST_TB_RD: state_in = scs_pkg::ST_TB_WR;
         scs_pkg::ST_TB_WR: begin
            if ((i_next_tb == '0) && (j_next_tb == '0)) begin
               state_in = scs_pkg::ST_EM_RD;
            end else begin
               state_in = scs_pkg::ST_TB_RD;
            end
         end
         scs_pkg::ST_EM_RD: state_in = scs_pkg::ST_EM_LD;
         scs_pkg::ST_EM_LD: state_in = scs_pkg::ST_EM_OUT;
         scs_pkg::ST_EM_OUT: begin
            if (rsp_accept) begin
               state_in = rsp_last_ff ? scs_pkg::ST_IDLE : scs_pkg::ST_EM_RD;
            end
         end
         default: state_in = scs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      len1_in      = len1_ff;
      len2_in      = len2_ff;
      drop_in      = drop_ff;
      ovf_in       = ovf_ff;
      m_in         = m_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      left_in      = left_ff;
      diag_in      = diag_ff;
      k_in         = k_ff;
      rsp_sym_in   = rsp_sym_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      t1_we       = 1'b0;
      t2_we       = 1'b0;
      t1_waddr    = len1_ff[IDX_W-1:0];
      t2_waddr    = len2_ff[IDX_W-1:0];
      t1_raddr    = i_m1[IDX_W-1:0];
      t2_raddr    = j_m1[IDX_W-1:0];
      tbl_we      = 1'b0;
      tbl_waddr   = scs_pkg::tbl_addr(i_ff, j_ff);
      tbl_wdata   = cell_val;
      tbl_raddr_a = (state_ff == scs_pkg::ST_TB_RD) ? scs_pkg::tbl_addr(i_ff, j_m1)
                                                     : scs_pkg::tbl_addr(i_m1, j_ff);
      tbl_raddr_b = scs_pkg::tbl_addr(i_m1, j_ff);
      mrg_we      = 1'b0;
      mrg_waddr   = k_ff[MRG_AW-1:0];
      mrg_wdata   = take2 ? t2_rd_ff : t1_rd_ff;
      mrg_raddr   = k_m1[MRG_AW-1:0];

      unique case (state_ff)
         scs_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_kind)
                  scs_pkg::KIND_FIRST: begin
                     if (len1_ff == LEN_W'(scs_pkg::MAX_LEN)) begin
                        drop_in = 1'b1;
                     end else begin
                        t1_we   = 1'b1;
                        len1_in = len1_ff + LEN_W'(1);
                     end
                  end
                  scs_pkg::KIND_SECOND: begin
                     if (len2_ff == LEN_W'(scs_pkg::MAX_LEN)) begin
                        drop_in = 1'b1;
                     end else begin
                        t2_we   = 1'b1;
                        len2_in = len2_ff + LEN_W'(1);
                     end
                  end
                  scs_pkg::KIND_COMPUTE: begin
                     m_in    = len1_ff;
                     n_in    = len2_ff;
                     ovf_in  = drop_ff;
                     len1_in = '0;
                     len2_in = '0;
                     drop_in = 1'b0;
                     k_in    = '0;
                     left_in = '0;
                     diag_in = '0;
                     if (any_empty) begin
                        i_in = len1_ff;
                        j_in = len2_ff;
                     end else begin
                        i_in = LEN_W'(1);
                        j_in = LEN_W'(1);
                     end
                     if (pair_empty) begin
                        k_in         = CNT_W'(1);
                        rsp_sym_in   = '0;
                        rsp_last_in  = 1'b1;
                        rsp_empty_in = 1'b1;
                        rsp_ovf_in   = drop_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         scs_pkg::ST_FILL_RD: begin
         end
         scs_pkg::ST_FILL_WR: begin
            tbl_we = 1'b1;
            if (j_ff == n_ff) begin
               if (i_ff == m_ff) begin
                  i_in = m_ff;
                  j_in = n_ff;
               end else begin
                  i_in = i_ff + LEN_W'(1);
                  j_in = LEN_W'(1);
               end
               left_in = '0;
               diag_in = '0;
            end else begin
               j_in    = j_ff + LEN_W'(1);
               left_in = cell_val;
               diag_in = up_val;
            end
         end
         scs_pkg::ST_TB_RD: begin
         end
         scs_pkg::ST_TB_WR: begin
            mrg_we = 1'b1;
            k_in   = k_ff + CNT_W'(1);
            i_in   = i_next_tb;
            j_in   = j_next_tb;
         end
         scs_pkg::ST_EM_RD: begin
         end
         scs_pkg::ST_EM_LD: begin
            rsp_sym_in   = mrg_rd_ff;
            rsp_last_in  = (k_ff == CNT_W'(1));
            rsp_empty_in = 1'b0;
            rsp_ovf_in   = ovf_ff;
         end
         scs_pkg::ST_EM_OUT: begin
            if (rsp_accept) begin
               k_in = k_m1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scs_pkg::ST_IDLE;
         len1_ff  <= '0;
         len2_ff  <= '0;
         drop_ff  <= 1'b0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         len1_ff  <= len1_in;
         len2_ff  <= len2_in;
         drop_ff  <= drop_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff       <= ovf_in;
      m_ff         <= m_in;
      n_ff         <= n_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      left_ff      <= left_in;
      diag_ff      <= diag_in;
      rsp_sym_ff   <= rsp_sym_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (t1_we) begin
         t1_mem[t1_waddr] <= req_symbol;
      end
      t1_rd_ff <= t1_mem[t1_raddr];
   end

   always_ff @(posedge clock) begin
      if (t2_we) begin
         t2_mem[t2_waddr] <= req_symbol;
      end
      t2_rd_ff <= t2_mem[t2_raddr];
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      tbl_rd_a_ff <= tbl_mem[tbl_raddr_a];
      tbl_rd_b_ff <= tbl_mem[tbl_raddr_b];
   end

   always_ff @(posedge clock) begin
      if (mrg_we) begin
         mrg_mem[mrg_waddr] <= mrg_wdata;
      end
      mrg_rd_ff <= mrg_mem[mrg_raddr];
   end

endmodule
